// ===== sv/ctin_pkg.sv =====
`timescale 1ns / 1ps

package ctin_pkg;

  localparam int DAY_W = 20;
  localparam int VAL_W = 32;
  localparam int TIM_W = 21;   // signed elapsed days, also span and part
  localparam int MAG_W = 55;   // multiplicand magnitude
  localparam int WRK_W = 76;   // product / dividend / quotient word
  localparam int CNT_W = 7;

  localparam logic [CNT_W-1:0] MUL_STEPS = 7'd21;
  localparam logic [CNT_W-1:0] DIV_STEPS = 7'd76;

  localparam logic [1:0] CFG_TODAY  = 2'd0;
  localparam logic [1:0] CFG_NPTS   = 2'd1;
  localparam logic [1:0] CFG_SPREAD = 2'd2;
  localparam logic [1:0] CFG_RT     = 2'd3;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_START,
    OP_CMP,
    OP_FLAT_PREV,
    OP_DERR,
    OP_MUL_LO,
    OP_TAKE_LO,
    OP_MUL_HI,
    OP_TAKE_HI,
    OP_MUL_D,
    OP_DIV_SPAN,
    OP_TAKE_SPAN,
    OP_DIV_TS,
    OP_TAKE_TS,
    OP_FIN
  } dp_op_t;

  typedef struct packed {
    logic found;
    logic first;
    logic at_end;
    logic ts_zero;
    logic busy;
    logic out_free;
    logic rt_mode;
  } dp_stat_t;

  function automatic logic [TIM_W-1:0] abs_tim(input logic signed [TIM_W-1:0] v);
    return v[TIM_W-1] ? $unsigned(-v) : $unsigned(v);
  endfunction

  function automatic logic [WRK_W-1:0] abs_wrk(input logic signed [WRK_W-1:0] v);
    return v[WRK_W-1] ? $unsigned(-v) : $unsigned(v);
  endfunction

endpackage

// ===== sv/ctin_ram.sv =====
`timescale 1ns / 1ps

module ctin_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/ctin_ctrl.sv =====
`timescale 1ns / 1ps

module ctin_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_cmd,
  output logic              in_tready,
  input  ctin_pkg::dp_stat_t stat,
  output ctin_pkg::dp_op_t   op
);

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_CMP, S_CHK, S_MUL_LO, S_W_LO, S_MUL_HI, S_W_HI,
    S_MUL_D, S_W_D, S_DIV_SP, S_W_SP, S_DIV_TS, S_W_TS, S_FIN
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    op        = ctin_pkg::OP_NONE;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (in_cmd == ctin_pkg::CMD_QUERY) begin
            op        = ctin_pkg::OP_START;
            state_nxt = S_RD;
          end else begin
            op = ctin_pkg::OP_LOAD;
          end
        end
      end
      S_RD: begin
        if (stat.at_end) begin
          op        = ctin_pkg::OP_FLAT_PREV;
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        op = ctin_pkg::OP_CMP;
        if (!stat.found)      state_nxt = S_RD;
        else if (stat.first)  state_nxt = S_FIN;
        else if (stat.rt_mode) state_nxt = S_CHK;
        else                  state_nxt = S_MUL_D;
      end
      S_CHK: begin
        if (stat.ts_zero) begin
          op        = ctin_pkg::OP_DERR;
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_MUL_LO;
        end
      end
      S_MUL_LO: begin
        op        = ctin_pkg::OP_MUL_LO;
        state_nxt = S_W_LO;
      end
      S_W_LO: begin
        if (!stat.busy) begin
          op        = ctin_pkg::OP_TAKE_LO;
          state_nxt = S_MUL_HI;
        end
      end
      S_MUL_HI: begin
        op        = ctin_pkg::OP_MUL_HI;
        state_nxt = S_W_HI;
      end
      S_W_HI: begin
        if (!stat.busy) begin
          op        = ctin_pkg::OP_TAKE_HI;
          state_nxt = S_MUL_D;
        end
      end
      S_MUL_D: begin
        op        = ctin_pkg::OP_MUL_D;
        state_nxt = S_W_D;
      end
      S_W_D: begin
        if (!stat.busy) state_nxt = S_DIV_SP;
      end
      S_DIV_SP: begin
        op        = ctin_pkg::OP_DIV_SPAN;
        state_nxt = S_W_SP;
      end
      S_W_SP: begin
        if (!stat.busy) begin
          op        = ctin_pkg::OP_TAKE_SPAN;
          state_nxt = stat.rt_mode ? S_DIV_TS : S_FIN;
        end
      end
      S_DIV_TS: begin
        op        = ctin_pkg::OP_DIV_TS;
        state_nxt = S_W_TS;
      end
      S_W_TS: begin
        if (!stat.busy) begin
          op        = ctin_pkg::OP_TAKE_TS;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (stat.out_free) begin
          op        = ctin_pkg::OP_FIN;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ===== sv/ctin_dp.sv =====
`timescale 1ns / 1ps

module ctin_dp #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [1:0]                          cfg_addr,
  input  logic [19:0]                         cfg_wdata,
  input  ctin_pkg::dp_op_t                    op,
  output ctin_pkg::dp_stat_t                  stat,
  input  logic [5:0]                          entry_index,
  input  logic [ctin_pkg::DAY_W-1:0]          entry_date,
  input  logic signed [ctin_pkg::VAL_W-1:0]   entry_rate,
  input  logic signed [ctin_pkg::VAL_W-1:0]   entry_spread,
  input  logic [ctin_pkg::DAY_W-1:0]          query_date,
  input  logic signed [ctin_pkg::VAL_W-1:0]   swap_val,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [ctin_pkg::VAL_W-1:0]   fwd_rate,
  output logic                                held_flat,
  output logic                                div_error
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int IW = $clog2(TABLE_DEPTH + 1);
  localparam int DW = ctin_pkg::DAY_W;
  localparam int VW = ctin_pkg::VAL_W;
  localparam int TW = ctin_pkg::TIM_W;
  localparam int WW = ctin_pkg::WRK_W;
  localparam int MW = ctin_pkg::MAG_W;
  localparam int RW = DW + 2 * VW;

  // configuration
  logic [DW-1:0] today_r;
  logic [6:0]    npts_r;
  logic          spread_r;
  logic          rt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      today_r  <= '0;
      npts_r   <= 7'd1;
      spread_r <= 1'b0;
      rt_r     <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        ctin_pkg::CFG_TODAY:  today_r  <= cfg_wdata;
        ctin_pkg::CFG_NPTS:   npts_r   <= cfg_wdata[6:0];
        ctin_pkg::CFG_SPREAD: spread_r <= cfg_wdata[0];
        ctin_pkg::CFG_RT:     rt_r     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  logic [IW-1:0] n_eff;
  always_comb begin
    if (npts_r == '0)                            n_eff = IW'(1);
    else if (32'(npts_r) > 32'(TABLE_DEPTH))     n_eff = IW'(TABLE_DEPTH);
    else                                         n_eff = IW'(npts_r);
  end

  // table memory: {spread, rate, day}
  logic [IW-1:0] idx_r;
  logic [RW-1:0] rd_word;
  logic          ram_we;

  assign ram_we = (op == ctin_pkg::OP_LOAD) && (32'(entry_index) < 32'(TABLE_DEPTH));

  ctin_ram #(.WIDTH(RW), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(entry_index)),
    .wdata ({entry_spread, entry_rate, entry_date}),
    .raddr (idx_r[AW-1:0]),
    .rdata (rd_word)
  );

  logic [DW-1:0]        rd_day;
  logic signed [VW-1:0] rd_val;
  assign rd_day = rd_word[DW-1:0];
  assign rd_val = spread_r ? $signed(rd_word[RW-1:DW+VW]) : $signed(rd_word[DW+VW-1:DW]);

  // query state
  logic [DW-1:0]        qdate_r, prev_day_r, cur_day_r;
  logic signed [VW-1:0] swap_r, prev_val_r, cur_val_r;
  logic signed [WW-1:0] p1_r, acc_r;
  logic                 held_r, derr_r;

  logic signed [TW-1:0] tl, th, ts;
  logic [TW-1:0]        part, span;
  assign tl   = $signed({1'b0, prev_day_r}) - $signed({1'b0, today_r});
  assign th   = $signed({1'b0, cur_day_r}) - $signed({1'b0, today_r});
  assign ts   = $signed({1'b0, qdate_r}) - $signed({1'b0, today_r});
  assign part = {1'b0, qdate_r} - {1'b0, prev_day_r};
  assign span = {1'b0, cur_day_r} - {1'b0, prev_day_r};

  // shift-add multiplier / restoring divider
  logic [WW-1:0]                  work_r;
  logic [MW-1:0]                  ma_r;
  logic [TW-1:0]                  opb_r, rem_r, rem_nxt;
  logic [ctin_pkg::CNT_W-1:0]     cnt_r;
  logic                           div_mode_r, neg_r, busy;
  logic [TW:0]                    rem_sh;
  logic                           ge;
  logic signed [WW-1:0]           prod_s, d_sel;

  logic          start_mul, start_div, neg_in;
  logic [MW-1:0] mul_a;
  logic [TW-1:0] opb_in;
  logic [WW-1:0] div_n;

  assign busy    = (cnt_r != '0);
  assign rem_sh  = {rem_r, work_r[WW-1]};
  assign ge      = (rem_sh >= {1'b0, opb_r});
  assign rem_nxt = ge ? TW'(rem_sh - {1'b0, opb_r}) : rem_sh[TW-1:0];
  assign prod_s  = neg_r ? -$signed(work_r) : $signed(work_r);
  assign d_sel   = rt_r ? (acc_r - p1_r) : (WW'(cur_val_r) - WW'(prev_val_r));

  always_comb begin
    start_mul = 1'b0;
    start_div = 1'b0;
    neg_in    = 1'b0;
    mul_a     = '0;
    opb_in    = '0;
    div_n     = '0;
    case (op)
      ctin_pkg::OP_MUL_LO: begin
        start_mul = 1'b1;
        mul_a     = MW'(ctin_pkg::abs_wrk(WW'(prev_val_r)));
        opb_in    = ctin_pkg::abs_tim(tl);
        neg_in    = prev_val_r[VW-1] ^ tl[TW-1];
      end
      ctin_pkg::OP_MUL_HI: begin
        start_mul = 1'b1;
        mul_a     = MW'(ctin_pkg::abs_wrk(WW'(cur_val_r)));
        opb_in    = ctin_pkg::abs_tim(th);
        neg_in    = cur_val_r[VW-1] ^ th[TW-1];
      end
      ctin_pkg::OP_MUL_D: begin
        start_mul = 1'b1;
        mul_a     = MW'(ctin_pkg::abs_wrk(d_sel));
        opb_in    = part;
        neg_in    = d_sel[WW-1];
      end
      ctin_pkg::OP_DIV_SPAN: begin
        start_div = 1'b1;
        div_n     = work_r;
        opb_in    = span;
        neg_in    = neg_r;
      end
      ctin_pkg::OP_DIV_TS: begin
        start_div = 1'b1;
        div_n     = ctin_pkg::abs_wrk(acc_r);
        opb_in    = ctin_pkg::abs_tim(ts);
        neg_in    = acc_r[WW-1] ^ ts[TW-1];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start_mul) begin
      cnt_r <= ctin_pkg::MUL_STEPS;
    end else if (start_div) begin
      cnt_r <= ctin_pkg::DIV_STEPS;
    end else if (busy) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start_mul) begin
      work_r     <= '0;
      ma_r       <= mul_a;
      opb_r      <= opb_in;
      neg_r      <= neg_in;
      div_mode_r <= 1'b0;
    end else if (start_div) begin
      work_r     <= div_n;
      opb_r      <= opb_in;
      rem_r      <= '0;
      neg_r      <= neg_in;
      div_mode_r <= 1'b1;
    end else if (busy) begin
      if (div_mode_r) begin
        work_r <= {work_r[WW-2:0], ge};
        rem_r  <= rem_nxt;
      end else begin
        work_r <= {work_r[WW-2:0], 1'b0} + (opb_r[TW-1] ? WW'(ma_r) : '0);
        opb_r  <= {opb_r[TW-2:0], 1'b0};
      end
    end
  end

  // search and interpolation registers
  always_ff @(posedge clk) begin
    case (op)
      ctin_pkg::OP_START: begin
        qdate_r <= query_date;
        swap_r  <= swap_val;
        idx_r   <= '0;
        held_r  <= 1'b0;
        derr_r  <= 1'b0;
        acc_r   <= '0;
      end
      ctin_pkg::OP_CMP: begin
        if (stat.found) begin
          if (stat.first) begin
            acc_r  <= WW'(rd_val);
            held_r <= 1'b1;
          end else begin
            cur_day_r <= rd_day;
            cur_val_r <= rd_val;
          end
        end else begin
          prev_day_r <= rd_day;
          prev_val_r <= rd_val;
          idx_r      <= idx_r + 1'b1;
        end
      end
      ctin_pkg::OP_FLAT_PREV: begin
        acc_r  <= WW'(prev_val_r);
        held_r <= 1'b1;
      end
      ctin_pkg::OP_DERR:      derr_r <= 1'b1;
      ctin_pkg::OP_TAKE_LO:   p1_r   <= prod_s;
      ctin_pkg::OP_TAKE_HI:   acc_r  <= prod_s;
      ctin_pkg::OP_TAKE_SPAN: acc_r  <= (rt_r ? p1_r : WW'(prev_val_r)) + prod_s;
      ctin_pkg::OP_TAKE_TS:   acc_r  <= prod_s;
      default: ;
    endcase
  end

  // result register
  logic signed [WW-1:0] fin_sum;
  logic [WW-VW:0]       fin_top;
  logic signed [VW-1:0] fin_sat;
  logic                 out_valid_r, held_o_r, derr_o_r;
  logic signed [VW-1:0] fwd_r;

  assign fin_sum = acc_r + (spread_r ? WW'(swap_r) : '0);
  assign fin_top = fin_sum[WW-1:VW-1];
  always_comb begin
    if (derr_r)                                fin_sat = '0;
    else if (fin_top == '0 || fin_top == '1)   fin_sat = fin_sum[VW-1:0];
    else if (fin_sum[WW-1])                    fin_sat = {1'b1, {(VW-1){1'b0}}};
    else                                       fin_sat = {1'b0, {(VW-1){1'b1}}};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (op == ctin_pkg::OP_FIN) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op == ctin_pkg::OP_FIN) begin
      fwd_r    <= fin_sat;
      held_o_r <= held_r;
      derr_o_r <= derr_r;
    end
  end

  assign out_valid = out_valid_r;
  assign fwd_rate  = fwd_r;
  assign held_flat = held_o_r;
  assign div_error = derr_o_r;

  assign stat.found    = (rd_day >= qdate_r);
  assign stat.first    = (idx_r == '0);
  assign stat.at_end   = (idx_r == n_eff);
  assign stat.ts_zero  = (ts == '0);
  assign stat.busy     = busy;
  assign stat.out_free = !out_valid_r || out_ready;
  assign stat.rt_mode  = rt_r;

endmodule

// ===== sv/curve_table_interpolator.sv =====
`timescale 1ns / 1ps
// load request: one table entry written at the accept edge
// query request: each table entry scanned is a memory read then a compare; the query then ends
//   in a flat hold (first entry or past the last), a zero start time (value-times-time only),
//   linear (one 21-step multiply, one 76-step divide),
//   or value-times-time (three 21-step multiplies, two 76-step divides)
// one request in flight; the next is taken once the result sits in the output register
// reset (rst_n low, synchronous): control and config cleared, table contents kept

module curve_table_interpolator #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  // config write port
  input  logic         cfg_we,
  input  logic [1:0]   cfg_addr,
  input  logic [19:0]  cfg_wdata,
  // request channel
  input  logic         in_tvalid,
  output logic         in_tready,
  // tdata: entry_index[5:0], entry_date[25:6], entry_rate[57:26],
  //        entry_spread[89:58], query_date[109:90], swap_val[141:110], pad
  input  logic [143:0] in_tdata,
  // tuser: cmd (0 load, 1 query)
  input  logic         in_tuser,
  // result channel
  output logic         out_tvalid,
  input  logic         out_tready,
  // tdata: fwd_rate[31:0]
  output logic [31:0]  out_tdata,
  // tuser: held_flat[0], div_error[1]
  output logic [1:0]   out_tuser
);

  ctin_pkg::dp_op_t   dp_op;
  ctin_pkg::dp_stat_t dp_stat;

  logic signed [31:0] fwd_rate;
  logic               held_flat, div_error;

  // sequencer: search loop, multiply/divide steps, result handoff
  ctin_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_cmd    (in_tuser),
    .in_tready (in_tready),
    .stat      (dp_stat),
    .op        (dp_op)
  );

  // table memory, arithmetic unit and output register
  ctin_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata),
    .op           (dp_op),
    .stat         (dp_stat),
    .entry_index  (in_tdata[5:0]),
    .entry_date   (in_tdata[25:6]),
    .entry_rate   ($signed(in_tdata[57:26])),
    .entry_spread ($signed(in_tdata[89:58])),
    .query_date   (in_tdata[109:90]),
    .swap_val     ($signed(in_tdata[141:110])),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .fwd_rate     (fwd_rate),
    .held_flat    (held_flat),
    .div_error    (div_error)
  );

  assign out_tdata = fwd_rate;
  assign out_tuser = {div_error, held_flat};

  // a divide error result carries zero and is never a flat hold
  a_derr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tdata == 32'd0 && !out_tuser[0])
    else $error("div_error result not zero");

  // arithmetic unit is quiet whenever new requests are taken
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !dp_stat.busy)
    else $error("arith unit busy while ready");

  // an accepted query blocks the request side on the next cycle
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser |=> !in_tready)
    else $error("query did not hold off requests");

endmodule

// ===== sim/curve_rate_checker.sv =====
`timescale 1ns / 1ps

module curve_rate_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_addr,
  input  logic [19:0]  cfg_wdata,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [143:0] in_tdata,
  input  logic         in_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [31:0]  out_tdata,
  input  logic [1:0]   out_tuser,
  output int           fail_count,
  output int           pending
);

  typedef struct {
    logic [31:0] rate;
    logic        flat;
    logic        derr;
  } fwd_result_t;

  logic [19:0] days[64];
  logic [31:0] rates[64];
  logic [31:0] spreads[64];
  logic [19:0] today_r;
  logic [6:0]  npts_r;
  logic        spread_r;
  logic        rt_r;
  fwd_result_t fwd_q[$];

  assign pending = fwd_q.size();

  function automatic longint pick_value(int idx);
    return spread_r ? longint'(signed'(spreads[idx])) : longint'(signed'(rates[idx]));
  endfunction

  // d * f / n truncated toward zero
  function automatic longint frac_scale(longint d, longint f, longint n);
    longint unsigned m, q;
    m = d < 0 ? -d : d;
    q = (m / n) * f + ((m % n) * f) / n;
    return d < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic fwd_result_t predict_rate(logic [19:0] qdate, logic [31:0] swap);
    fwd_result_t r;
    int n, i;
    longint st, ts, tl, th, lo, hi, acc;
    n = npts_r == 0 ? 1 : (npts_r > 64 ? 64 : npts_r);
    st = qdate;
    acc = 0;
    r.flat = 0;
    r.derr = 0;
    i = 0;
    while (i < n && longint'(days[i]) < st) i++;
    if (i == n || i == 0) begin
      acc = pick_value(i == 0 ? 0 : n - 1);
      r.flat = 1;
    end else begin
      ts = st - today_r;
      tl = longint'(days[i-1]) - today_r;
      th = longint'(days[i]) - today_r;
      lo = pick_value(i - 1);
      hi = pick_value(i);
      if (!rt_r) acc = lo + frac_scale(hi - lo, ts - tl, th - tl);
      else if (ts == 0) r.derr = 1;
      else acc = (lo * tl + frac_scale(hi * th - lo * tl, ts - tl, th - tl)) / ts;
    end
    if (!r.derr && spread_r) acc += longint'(signed'(swap));
    if (r.derr) acc = 0;
    if (acc > 64'sd2147483647) acc = 64'sd2147483647;
    if (acc < -64'sd2147483648) acc = -64'sd2147483648;
    r.rate = acc[31:0];
    return r;
  endfunction

  always @(posedge clk) begin
    fwd_result_t exp_r;
    if (!rst_n) begin
      today_r <= '0; npts_r <= 7'd1; spread_r <= 1'b0; rt_r <= 1'b0;
      fail_count <= 0;
      fwd_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          ctin_pkg::CFG_TODAY:  today_r  <= cfg_wdata;
          ctin_pkg::CFG_NPTS:   npts_r   <= cfg_wdata[6:0];
          ctin_pkg::CFG_SPREAD: spread_r <= cfg_wdata[0];
          ctin_pkg::CFG_RT:     rt_r     <= cfg_wdata[0];
          default: ;
        endcase
      end
      // compare first: a result cannot be caused by a request taken this edge
      if (out_tvalid && out_tready) begin
        if (fwd_q.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected result %h/%b", out_tdata, out_tuser);
        end else begin
          exp_r = fwd_q.pop_front();
          if (out_tdata !== exp_r.rate || out_tuser[0] !== exp_r.flat ||
              out_tuser[1] !== exp_r.derr) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("mismatch: expected rate %h flat %b derr %b, got %h flat %b derr %b",
                       exp_r.rate, exp_r.flat, exp_r.derr, out_tdata, out_tuser[0],
                       out_tuser[1]);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser == ctin_pkg::CMD_LOAD) begin
          days[in_tdata[5:0]]    = in_tdata[25:6];
          rates[in_tdata[5:0]]   = in_tdata[57:26];
          spreads[in_tdata[5:0]] = in_tdata[89:58];
        end else
          fwd_q.push_back(predict_rate(in_tdata[109:90], in_tdata[141:110]));
      end
    end
  end
endmodule

// ===== sim/curve_table_interpolator_tb.sv =====
`timescale 1ns / 1ps

module curve_table_interpolator_tb;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_we = 1'b0;
  logic [1:0]   cfg_addr = '0;
  logic [19:0]  cfg_wdata = '0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [143:0] in_tdata = '0;
  logic         in_tuser = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [31:0]  out_tdata;
  logic [1:0]   out_tuser;
  int           fail_count;
  int           pending;

  // idle percentages, switched by phase
  int send_idle_pct = 38;
  int recv_idle_pct = 54;
  int hold_off_cycles = 0;
  longint cycle_count = 0;

  // table image kept here so queries only touch written slots
  logic [19:0] day_img[64];
  int loaded_upto = 0;   // slots 0..loaded_upto-1 written
  int npts_now = 1;
  logic [19:0] today_now = '0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  curve_table_interpolator DUT (.*);

  curve_rate_checker checker_i (.*);

  // receiver: random stalls, plus a long hold-off when asked
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_tready <= 1'b0;
    end else
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // generous overall limit on the run, receiver stalls included
  always @(posedge clk) begin
    if (cycle_count > 900000) begin
      $display("curve_table_interpolator verification failed");
      $finish;
    end
  end

  // valid stays up after an accept until the next request or an idle cycle
  task automatic send_request(logic cmd, logic [143:0] payload);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= payload;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic stop_sending;
    in_tvalid <= 1'b0;
  endtask

  task automatic load_entry(int idx, logic [19:0] day, logic [31:0] rate, logic [31:0] spr);
    logic [143:0] p;
    p = '0;
    p[5:0] = idx[5:0]; p[25:6] = day; p[57:26] = rate; p[89:58] = spr;
    // random junk in query fields exercises those bits on loads too
    p[109:90] = 20'($urandom); p[141:110] = $urandom;
    send_request(ctin_pkg::CMD_LOAD, p);
    day_img[idx] = day;
    if (idx == loaded_upto) loaded_upto++;
  endtask

  task automatic query_rate(logic [19:0] qd, logic [31:0] swap);
    logic [143:0] p;
    p = '0;
    p[5:0] = 6'($urandom); p[25:6] = 20'($urandom);
    p[57:26] = $urandom; p[89:58] = $urandom;
    p[109:90] = qd; p[141:110] = swap;
    send_request(ctin_pkg::CMD_QUERY, p);
  endtask

  // wait for all results, then the block's longest query latency
  task automatic drain;
    stop_sending();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  // config only changes once every query has returned
  task automatic write_reg(logic [1:0] addr, logic [19:0] val);
    stop_sending();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    cfg_we <= 1'b1; cfg_addr <= addr; cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (addr == ctin_pkg::CFG_NPTS) npts_now = val[6:0];
    if (addr == ctin_pkg::CFG_TODAY) today_now = val;
  endtask

  // ascending table of n entries starting near base day
  task automatic load_sorted(int n, int base, int step_max);
    int d;
    d = base;
    loaded_upto = 0;
    for (int k = 0; k < n; k++) begin
      load_entry(k, d[19:0], $urandom, $urandom);
      d += $urandom_range(step_max, 1);
      if (d > 20'hFFFFF) d = 20'hFFFFF;
    end
  endtask

  function automatic logic [19:0] pick_query_day();
    int n, k;
    n = npts_now == 0 ? 1 : (npts_now > 64 ? 64 : npts_now);
    k = $urandom_range(n - 1);
    case ($urandom_range(5))
      0: return day_img[k];
      1: return today_now;
      2: return 20'(day_img[0] - $urandom_range(3));
      3: return 20'(day_img[n-1] + $urandom_range(3));
      4: return 20'($urandom);
      default: return 20'(day_img[k] - $urandom_range(40));
    endcase
  endfunction

  task automatic random_queries(int count);
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(9) == 0)
        load_entry($urandom_range(loaded_upto - 1), 20'($urandom), $urandom, $urandom);
      else
        query_rate(pick_query_day(), $urandom);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: single entry, extremes of values and days
    load_entry(0, 20'd100, 32'h7FFFFFFF, 32'h80000000);
    query_rate(20'd0, 32'h0);
    query_rate(20'hFFFFF, 32'h7FFFFFFF);
    write_reg(ctin_pkg::CFG_NPTS, 20'd0);          // acts as one entry
    query_rate(20'd100, 32'h12345678);
    write_reg(ctin_pkg::CFG_SPREAD, 20'd1);
    query_rate(20'd50, 32'h7FFFFFFF);      // spread of the first entry plus swap
    write_reg(ctin_pkg::CFG_SPREAD, 20'd0);
    load_entry(1, 20'd200, 32'h80000000, 32'h7FFFFFFF);
    load_entry(2, 20'hFFFFF, 32'h01000000, 32'hFF000000);
    load_entry(3, 20'd150, 32'h00000000, 32'h00000001); // unsorted
    write_reg(ctin_pkg::CFG_NPTS, 20'd127);        // clips to table depth... only 4 written
    write_reg(ctin_pkg::CFG_NPTS, 20'd4);
    query_rate(20'd150, 32'h0);
    query_rate(20'd101, 32'h0);
    query_rate(20'd200, 32'h0);
    query_rate(20'd201, 32'hFFFFFFFF);
    write_reg(ctin_pkg::CFG_RT, 20'd1);
    write_reg(ctin_pkg::CFG_TODAY, 20'd120);
    query_rate(20'd120, 32'h0);            // zero elapsed start
    query_rate(20'd110, 32'h0);            // negative elapsed
    query_rate(20'd180, 32'h0);
    write_reg(ctin_pkg::CFG_SPREAD, 20'd1);
    query_rate(20'd120, 32'h7FFFFFFF);     // flag, swap not added
    query_rate(20'd190, 32'h80000000);
    load_entry(63, 20'd5, 32'h1, 32'h2);   // top slot
    query_rate(20'hFFFFF, 32'h0);          // equals the largest written day, entry 2
    drain();

    // full depth table, then pressure: long receiver hold-off
    write_reg(ctin_pkg::CFG_TODAY, 20'd0);
    write_reg(ctin_pkg::CFG_RT, 20'd0);
    write_reg(ctin_pkg::CFG_SPREAD, 20'd0);
    load_sorted(64, 0, 16000);
    write_reg(ctin_pkg::CFG_NPTS, 20'd64);
    hold_off_cycles = 3000;
    random_queries(20);
    drain();

    // sweep settings, three idle profiles
    for (int ph = 0; ph < 12; ph++) begin
      send_idle_pct = ph < 4 ? 38 : (ph < 8 ? 54 : 0);
      recv_idle_pct = ph < 4 ? 54 : (ph < 8 ? 38 : 0);
      write_reg(ctin_pkg::CFG_TODAY,
                ph == 3 ? 20'hFFFFF : 20'(ph * 1000 + $urandom_range(5000)));
      write_reg(ctin_pkg::CFG_SPREAD, 20'(ph[0]));
      write_reg(ctin_pkg::CFG_RT, 20'(ph[1]));
      load_sorted(ph == 11 ? 64 : $urandom_range(12, 2), ph * 900, 800);
      write_reg(ctin_pkg::CFG_NPTS, 20'(loaded_upto));
      random_queries(35);
      // sender pauses until every result is back
      drain();
    end

    if (fail_count == 0)
      $display("curve_table_interpolator verification clean");
    else
      $display("curve_table_interpolator verification failed");
    $finish;
  end
endmodule

// ===== curve_table_interpolator.f =====
sv/ctin_pkg.sv
sv/ctin_ram.sv
sv/ctin_ctrl.sv
sv/ctin_dp.sv
sv/curve_table_interpolator.sv
sim/curve_rate_checker.sv
sim/curve_table_interpolator_tb.sv
